// File: rtl/core/smm_pkg.sv
// ----------------------------------------------------------------------------
// Square matrix multiply package
// Shared widths, operation codes and the queued operation type.
// ----------------------------------------------------------------------------
package smm_pkg;

    // Default sizes of the matrices.
    localparam int DIM_DEF        = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed port widths.
    localparam int CMD_W = 2;
    localparam int IDX_W = 3;
    localparam int VAL_W = 16;

    // Commands on the input port.
    localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RD   = 2'd2;

    // Operations handed from the front to the back.
    localparam logic [1:0] OP_WR_A    = 2'd0;
    localparam logic [1:0] OP_WR_B    = 2'd1;
    localparam logic [1:0] OP_RD      = 2'd2;
    localparam logic [1:0] OP_RD_ZERO = 2'd3;

    // One classified operation.
    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_op;

endpackage

// File: rtl/core/smm_front.sv
// ----------------------------------------------------------------------------
// Square matrix multiply front end
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module smm_front import smm_pkg::*; #(
    parameter int DIM = DIM_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [IDX_W-1:0] i_row,
    input  logic [IDX_W-1:0] i_col,
    input  logic [VAL_W-1:0] i_elem_value,
    output t_op              o_op,
    output logic             o_op_vld,
    input  logic             i_op_take
);

    localparam int CMP_W = 8;

    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    t_op        cls_op;
    logic       cls_keep;
    logic       in_range;
    logic       xfer_in;
    logic       xfer_out;
    logic       do_push;

    // Classify the incoming command; unused commands and stray writes are dropped.
    always_comb begin
        in_range = (CMP_W'(i_row) < CMP_W'(DIM)) && (CMP_W'(i_col) < CMP_W'(DIM));
        cls_op.row   = i_row;
        cls_op.col   = i_col;
        cls_op.value = i_elem_value;
        cls_op.kind  = OP_RD_ZERO;
        cls_keep     = 1'b0;
        unique case (i_cmd)
            CMD_WR_A: begin
                cls_op.kind = OP_WR_A;
                cls_keep    = in_range;
            end
            CMD_WR_B: begin
                cls_op.kind = OP_WR_B;
                cls_keep    = in_range;
            end
            CMD_RD: begin
                cls_op.kind = in_range ? OP_RD : OP_RD_ZERO;
                cls_keep    = 1'b1;
            end
            default: begin
                cls_keep = 1'b0;
            end
        endcase
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_op_vld = (r_cnt != 2'd0);
    assign o_op     = r_q[r_rp];
    assign xfer_in  = i_push && !o_full;
    assign xfer_out = o_op_vld && i_op_take;
    assign do_push  = xfer_in && cls_keep;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cls_op;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (xfer_out) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, xfer_out};
        end
    end

endmodule

// File: rtl/core/smm_back.sv
// ----------------------------------------------------------------------------
// Square matrix multiply back end
// Holds both matrices, runs the multiply-accumulate walk and queues results.
// ----------------------------------------------------------------------------
module smm_back import smm_pkg::*; #(
    parameter int DIM        = DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_op              i_op,
    input  logic             i_op_vld,
    output logic             o_op_take,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [VAL_W-1:0] o_product_value
);

    localparam int EW     = ELEM_WIDTH;
    localparam int DEPTH  = DIM * DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CALC_W = 16;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [KW-1:0]    r_k, n_k;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;

    logic [EW-1:0]    mem_a [DEPTH];
    logic [EW-1:0]    mem_b [DEPTH];

    logic [EW-1:0]    r_a_data, r_b_data;
    logic             r_rd_vld, r_rd_last;
    logic [EW-1:0]    r_prod;
    logic             r_prod_vld, r_prod_last;
    logic [EW-1:0]    r_acc, n_acc;

    logic [VAL_W-1:0] r_res [2];
    logic             r_res_wp, r_res_rp;
    logic [1:0]       r_res_cnt;

    logic             res_room;
    logic             res_push;
    logic [VAL_W-1:0] res_data;
    logic             res_pop;
    logic             wr_a, wr_b;
    logic             rd_en;
    logic             k_last;
    logic             acc_done;

    logic [CALC_W-1:0]   wr_addr_full, a_addr_full, b_addr_full;
    logic [AW-1:0]       wr_addr, a_addr, b_addr;
    logic [EW+VAL_W-1:0] wr_ext;
    logic [EW-1:0]       wr_data;
    logic [2*EW-1:0]     mul_full;

    assign res_room = (r_res_cnt != 2'd2);
    assign k_last   = (r_k == KW'(DIM - 1));
    assign acc_done = r_prod_vld && r_prod_last;
    assign n_acc    = r_acc + r_prod;

    // Write address and value, trimmed to the element width.
    assign wr_addr_full = CALC_W'(i_op.row) * CALC_W'(DIM) + CALC_W'(i_op.col);
    assign wr_addr      = wr_addr_full[AW-1:0];
    assign wr_ext       = {{EW{1'b0}}, i_op.value};
    assign wr_data      = wr_ext[EW-1:0];

    // Walk addresses: row of A and column of B at step k.
    assign a_addr_full = CALC_W'(r_row) * CALC_W'(DIM) + CALC_W'(r_k);
    assign b_addr_full = CALC_W'(r_k) * CALC_W'(DIM) + CALC_W'(r_col);
    assign a_addr      = a_addr_full[AW-1:0];
    assign b_addr      = b_addr_full[AW-1:0];

    // Sequencer: writes finish at once, in-range reads walk DIM steps, out-of-range reads push zero.
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_row     = r_row;
        n_col     = r_col;
        o_op_take = 1'b0;
        wr_a      = 1'b0;
        wr_b      = 1'b0;
        rd_en     = 1'b0;
        res_push  = 1'b0;
        res_data  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_vld) begin
                    case (i_op.kind)
                        OP_WR_A: begin
                            o_op_take = 1'b1;
                            wr_a      = 1'b1;
                        end
                        OP_WR_B: begin
                            o_op_take = 1'b1;
                            wr_b      = 1'b1;
                        end
                        OP_RD: begin
                            if (res_room) begin
                                o_op_take = 1'b1;
                                n_row     = i_op.row;
                                n_col     = i_op.col;
                                n_k       = '0;
                                n_state   = S_ISSUE;
                            end
                        end
                        default: begin
                            if (res_room) begin
                                o_op_take = 1'b1;
                                res_push  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                rd_en = 1'b1;
                n_k   = r_k + KW'(1);
                if (k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (acc_done) begin
                    res_push = 1'b1;
                    res_data = VAL_W'({{VAL_W{1'b0}}, n_acc});
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Matrix memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_a_data <= mem_a[a_addr];
            r_b_data <= mem_b[b_addr];
        end
    end

    // Shared multiplier, keeping the wrapped low half.
    assign mul_full = r_a_data * r_b_data;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= mul_full[EW-1:0];
        end
    end

    // Accumulator, cleared when a read starts.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= n_acc;
        end
    end

    // Sequencer state and pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_row       <= n_row;
            r_col       <= n_col;
            r_rd_vld    <= rd_en;
            r_rd_last   <= rd_en && k_last;
            r_prod_vld  <= r_rd_vld;
            r_prod_last <= r_rd_last;
        end
    end

    // Result queue: two entries; a read starts only while it has room, so a walk never stalls on it.
    assign o_empty         = (r_res_cnt == 2'd0);
    assign o_product_value = r_res[r_res_rp];
    assign res_pop         = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wp] <= res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wp  <= 1'b0;
            r_res_rp  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (res_push) begin
                r_res_wp <= ~r_res_wp;
            end
            if (res_pop) begin
                r_res_rp <= ~r_res_rp;
            end
            r_res_cnt <= r_res_cnt + {1'b0, res_push} - {1'b0, res_pop};
        end
    end

endmodule

// File: rtl/core/square_matrix_multiply.sv
// ----------------------------------------------------------------------------
// Square matrix multiply
// Stores matrices A and B and returns single elements of their product.
// ----------------------------------------------------------------------------
// Each input transfer writes one element of A, writes one element of B, or
// asks for one element C[row][col] of A times B; only a request returns a
// result, and the sum wraps at the element width. Requests with a row or
// column outside the matrix return zero, writes outside it are dropped, and
// the unused command is ignored. A two-entry input queue takes items while
// the back end works. In the back end a write goes straight to its matrix
// memory; a product request walks the DIM terms from the two matrix
// memories with one shared multiplier, one term per cycle, and an
// out-of-range request pushes a zero result. Results wait in a two-entry
// output queue. Elements must be written before they are used.
// ----------------------------------------------------------------------------
module square_matrix_multiply import smm_pkg::*; #(
    parameter int DIM        = DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [IDX_W-1:0] i_row,
    input  logic [IDX_W-1:0] i_col,
    input  logic [VAL_W-1:0] i_elem_value,
    output logic             empty,
    input  logic             pop,
    output logic [VAL_W-1:0] o_product_value
);

    t_op  op;
    logic op_vld;
    logic op_take;

    // Front end: classify and queue.
    smm_front #(
        .DIM (DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_elem_value (i_elem_value),
        .o_op         (op),
        .o_op_vld     (op_vld),
        .i_op_take    (op_take)
    );

    // Back end: memories, multiply-accumulate and result queue.
    smm_back #(
        .DIM        (DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_op_vld        (op_vld),
        .o_op_take       (op_take),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_product_value (o_product_value)
    );

endmodule
